FILE: hw/rtl/lgre_pkg.sv
`timescale 1ns / 1ps

package lgre_pkg;

   localparam int ROW_WIDTH   = 64;
   localparam int COUNT_WIDTH = 7;
   localparam int MAX_COLUMNS = 64;

   // column count at reset covers the whole row
   localparam logic [COUNT_WIDTH-1:0] COLUMN_COUNT_RESET = COUNT_WIDTH'(64);

   typedef struct packed {
      logic [ROW_WIDTH-1:0] row_cells;
      logic                 last_row;
   } lgre_req_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0] next_cells;
      logic                 board_done;
   } lgre_rsp_type;

   // valid-column mask, count saturates at the column limit
   function automatic logic [ROW_WIDTH-1:0] col_mask(input logic [COUNT_WIDTH-1:0] count);
      logic [COUNT_WIDTH-1:0] n;
      logic [ROW_WIDTH-1:0]   m;
      n = count;
      if (n > COUNT_WIDTH'(MAX_COLUMNS)) begin
         n = COUNT_WIDTH'(MAX_COLUMNS);
      end
      if (n >= COUNT_WIDTH'(ROW_WIDTH)) begin
         m = '1;
      end else begin
         m = (ROW_WIDTH'(1) << n) - ROW_WIDTH'(1);
      end
      return m;
   endfunction

endpackage

FILE: hw/rtl/lgre_next_row.sv
`timescale 1ns / 1ps

module lgre_next_row
   import lgre_pkg::*;
(
   input  logic [ROW_WIDTH-1:0] row_up,
   input  logic [ROW_WIDTH-1:0] row_mid,
   input  logic [ROW_WIDTH-1:0] row_down,
   input  logic [ROW_WIDTH-1:0] col_mask_bits,
   output logic [ROW_WIDTH-1:0] row_next
);

   // rows padded with a dead cell on each side
   logic [ROW_WIDTH+1:0] up_x;
   logic [ROW_WIDTH+1:0] mid_x;
   logic [ROW_WIDTH+1:0] down_x;
   logic [ROW_WIDTH-1:0] live;

   assign up_x   = {1'b0, row_up   & col_mask_bits, 1'b0};
   assign mid_x  = {1'b0, row_mid  & col_mask_bits, 1'b0};
   assign down_x = {1'b0, row_down & col_mask_bits, 1'b0};

   for (genvar i = 0; i < ROW_WIDTH; i++) begin : g_cell
      logic [3:0] ncount;
      assign ncount = 4'(up_x[i])   + 4'(up_x[i+1])   + 4'(up_x[i+2])
                    + 4'(mid_x[i])                    + 4'(mid_x[i+2])
                    + 4'(down_x[i]) + 4'(down_x[i+1]) + 4'(down_x[i+2]);
      // birth on three, survival on two or three
      assign live[i] = (ncount == 4'd3) || (mid_x[i+1] && (ncount == 4'd2));
   end

   assign row_next = live & col_mask_bits;

endmodule

FILE: hw/rtl/life_generation_row_engine.sv
`timescale 1ns / 1ps

// channel | direction | handshake              | payload
// req     | in        | req_valid / req_stall  | lgre_req_type (row_cells, last_row)
// rsp     | out       | rsp_valid / rsp_stall  | lgre_rsp_type (next_cells, board_done)
// csr     | in        | csr_wr_en              | csr_wr_data (column_count)
//
// one row item per cycle unless stalled; a result passes the job and result registers
// a bottom row that follows a pending row gives two results; req stalls for the second
// the job register feeds one combinational neighbor-count pass into the result register
// reset (synchronous) clears kept rows, jobs and rsp_valid; column count returns to 64
// rsp_stall propagates into req_stall only when the job register cannot drain

module life_generation_row_engine
   import lgre_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lgre_req_type           req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lgre_rsp_type           rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [COUNT_WIDTH-1:0] csr_wr_data
);

   // column mask, rebuilt at each csr write
   logic [ROW_WIDTH-1:0] col_mask_ff;

   // board state: row above the pending row, the pending row
   logic [ROW_WIDTH-1:0] row_above_ff;
   logic [ROW_WIDTH-1:0] row_pending_ff;
   logic                 have_pending_ff;

   // job register: three rows r0 r1 r2
   // job a = (r0, r1, r2) for the pending row
   // job b = (r1, r2, dead) for the bottom row
   logic [ROW_WIDTH-1:0] job_r0_ff;
   logic [ROW_WIDTH-1:0] job_r1_ff;
   logic [ROW_WIDTH-1:0] job_r2_ff;
   logic                 job_a_ff, job_a_in;
   logic                 job_b_ff, job_b_in;

   // result register
   logic                 rsp_valid_ff;
   lgre_rsp_type         rsp_payload_ff, rsp_payload_in;

   logic                 move;
   logic                 job_a_left;
   logic                 job_b_left;
   logic                 accept;
   logic [ROW_WIDTH-1:0] cur_row;
   logic [ROW_WIDTH-1:0] calc_up;
   logic [ROW_WIDTH-1:0] calc_mid;
   logic [ROW_WIDTH-1:0] calc_down;
   logic [ROW_WIDTH-1:0] calc_next;

   // a job moves into the result register when that register is free or draining
   assign move       = (job_a_ff || job_b_ff) && (!rsp_valid_ff || !rsp_stall);
   // job a always goes first
   assign job_a_left = job_a_ff && !move;
   assign job_b_left = job_b_ff && !(move && !job_a_ff);

   assign req_stall  = job_a_left || job_b_left;
   assign accept     = req_valid && !req_stall;
   assign cur_row    = req_payload.row_cells & col_mask_ff;

   assign job_a_in   = accept ? have_pending_ff : job_a_left;
   assign job_b_in   = accept ? req_payload.last_row : job_b_left;

   // pick the rows for the job that moves this cycle
   assign calc_up    = job_a_ff ? job_r0_ff : job_r1_ff;
   assign calc_mid   = job_a_ff ? job_r1_ff : job_r2_ff;
   assign calc_down  = job_a_ff ? job_r2_ff : '0;

   lgre_next_row u_next_row (
      .row_up        (calc_up),
      .row_mid       (calc_mid),
      .row_down      (calc_down),
      .col_mask_bits (col_mask_ff),
      .row_next      (calc_next)
   );

   always_comb begin
      rsp_payload_in.next_cells = calc_next;
      rsp_payload_in.board_done = !job_a_ff;
   end

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         col_mask_ff <= col_mask(COLUMN_COUNT_RESET);
      end else if (csr_wr_en) begin
         col_mask_ff <= col_mask(csr_wr_data);
      end
   end

   // board state and job flags
   always_ff @(posedge clock) begin
      if (reset) begin
         row_above_ff    <= '0;
         row_pending_ff  <= '0;
         have_pending_ff <= 1'b0;
         job_a_ff        <= 1'b0;
         job_b_ff        <= 1'b0;
      end else begin
         job_a_ff <= job_a_in;
         job_b_ff <= job_b_in;
         if (accept) begin
            if (req_payload.last_row) begin
               // board finished, next item starts under a dead border
               row_above_ff    <= '0;
               row_pending_ff  <= '0;
               have_pending_ff <= 1'b0;
            end else begin
               row_above_ff    <= have_pending_ff ? row_pending_ff : '0;
               row_pending_ff  <= cur_row;
               have_pending_ff <= 1'b1;
            end
         end
      end
   end

   // job rows, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         job_r0_ff <= row_above_ff;
         job_r1_ff <= have_pending_ff ? row_pending_ff : '0;
         job_r2_ff <= cur_row;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef ASSERT_OFF
   // with both jobs queued, no new row can be taken
   a_two_jobs_stall: assert property (@(posedge clock) disable iff (reset)
      (job_a_ff && job_b_ff) |-> req_stall)
      else $error("row taken while two jobs queued");

   // a bottom row closes the board
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.last_row) |=> !have_pending_ff)
      else $error("pending row kept after bottom row");

   // any other row becomes pending
   a_row_pending: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_payload.last_row) |=> (have_pending_ff && !job_b_ff))
      else $error("row not kept as pending");

   // no live cell beyond the column count
   a_mask_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_payload_ff.next_cells & ~col_mask_ff) == '0))
      else $error("live cell beyond column count");
`endif

endmodule
